// ----- rtl/core/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, codes and character classes for the collation rule tokenizer.
// ----------------------------------------------------------------------------
package crt_pkg;

    // Result kinds
    localparam logic [2:0] KIND_CHARS = 3'd0;
    localparam logic [2:0] KIND_EXT   = 3'd1;
    localparam logic [2:0] KIND_ENTRY = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_NONE  = 3'd4;

    // Entry strengths; UNSET marks "no entry open"
    localparam logic [2:0] STR_PRIMARY   = 3'd0;
    localparam logic [2:0] STR_SECONDARY = 3'd1;
    localparam logic [2:0] STR_TERTIARY  = 3'd2;
    localparam logic [2:0] STR_IDENTICAL = 3'd3;
    localparam logic [2:0] STR_RESET     = 3'd4;
    localparam logic [2:0] STR_UNSET     = 3'd7;

    // Quote modes
    localparam logic [1:0] QM_OFF     = 2'd0;
    localparam logic [1:0] QM_LITERAL = 2'd1;
    localparam logic [1:0] QM_INSIDE  = 2'd2;

    // Code units with a meaning of their own
    localparam logic [15:0] CU_EQUAL = 16'h003D;
    localparam logic [15:0] CU_COMMA = 16'h002C;
    localparam logic [15:0] CU_SEMI  = 16'h003B;
    localparam logic [15:0] CU_LESS  = 16'h003C;
    localparam logic [15:0] CU_AMP   = 16'h0026;
    localparam logic [15:0] CU_SLASH = 16'h002F;
    localparam logic [15:0] CU_QUOTE = 16'h0027;
    localparam logic [15:0] CU_TAB   = 16'h0009;
    localparam logic [15:0] CU_LF    = 16'h000A;
    localparam logic [15:0] CU_FF    = 16'h000C;
    localparam logic [15:0] CU_CR    = 16'h000D;
    localparam logic [15:0] CU_SPACE = 16'h0020;

    // Result queue depth; must hold two results beyond a full output
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] char_out;
        logic [2:0]  strength;
        logic        run_last;
    } result_t;

    function automatic logic is_special(input logic [15:0] cu);
        return (cu >= 16'h0020 && cu <= 16'h002F) ||
               (cu >= 16'h003A && cu <= 16'h003F) ||
               (cu >= 16'h005B && cu <= 16'h0060) ||
               (cu >= 16'h007B && cu <= 16'h007E);
    endfunction

    function automatic logic is_space(input logic [15:0] cu);
        return (cu == CU_TAB) || (cu == CU_LF) || (cu == CU_FF) ||
               (cu == CU_CR) || (cu == CU_SPACE);
    endfunction

    function automatic logic [2:0] symbol_strength(input logic [15:0] cu);
        logic [2:0] s;
        case (cu)
            CU_EQUAL: s = STR_IDENTICAL;
            CU_COMMA: s = STR_TERTIARY;
            CU_SEMI:  s = STR_SECONDARY;
            CU_LESS:  s = STR_PRIMARY;
            CU_AMP:   s = STR_RESET;
            default:  s = STR_UNSET;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/core/crt_parse.sv -----
// ----------------------------------------------------------------------------
// crt_parse
// Tokenizer state and per-unit decode; yields up to two results per unit.
// ----------------------------------------------------------------------------
module crt_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [15:0]          cu,
    input  logic                 last,
    output logic [1:0]           push_n,
    output crt_pkg::result_t     res0,
    output crt_pkg::result_t     res1
);

    logic [2:0] open_reg,   open_next;
    logic       in_chars_reg, in_chars_next;
    logic [1:0] quote_reg,  quote_next;
    logic       seen_reg,   seen_next;
    logic       err_reg,    err_next;

    always_comb
    begin
        crt_pkg::result_t own;
        crt_pkg::result_t cls;
        logic             own_v;
        logic             cls_v;
        logic             fail;
        logic [2:0]       sym;

        open_next     = open_reg;
        in_chars_next = in_chars_reg;
        quote_next    = quote_reg;
        seen_next     = seen_reg;
        err_next      = err_reg;
        own           = '0;
        cls           = '0;
        own_v         = 1'b0;
        cls_v         = 1'b0;
        fail          = 1'b0;
        sym           = crt_pkg::symbol_strength(cu);

        if (err_reg)
        begin
            // swallow units until the pattern ends
        end
        else if (quote_reg != crt_pkg::QM_OFF && !(quote_reg == crt_pkg::QM_INSIDE
                 && cu == crt_pkg::CU_QUOTE))
        begin
            // quoted unit: chars if chars empty or chars part active
            own_v        = 1'b1;
            own.char_out = cu;
            if (!seen_reg || in_chars_reg)
            begin
                seen_next = 1'b1;
                own.kind  = crt_pkg::KIND_CHARS;
            end
            else
            begin
                own.kind  = crt_pkg::KIND_EXT;
            end
            quote_next = crt_pkg::QM_INSIDE;
        end
        else if (quote_reg == crt_pkg::QM_INSIDE)
        begin
            quote_next = crt_pkg::QM_OFF;      // closing quote
        end
        else if (sym != crt_pkg::STR_UNSET)
        begin
            if (open_reg == crt_pkg::STR_UNSET)
            begin
                open_next = sym;
            end
            else if (!seen_reg)
            begin
                own_v    = 1'b1;
                own.kind = crt_pkg::KIND_ERROR;
                fail     = 1'b1;
            end
            else
            begin
                own_v         = 1'b1;
                own.kind      = crt_pkg::KIND_ENTRY;
                own.strength  = open_reg;
                open_next     = sym;
                in_chars_next = 1'b1;
                quote_next    = crt_pkg::QM_OFF;
                seen_next     = 1'b0;
            end
        end
        else if (crt_pkg::is_space(cu))
        begin
            // skipped
        end
        else if (cu == crt_pkg::CU_SLASH)
        begin
            in_chars_next = 1'b0;
        end
        else if (cu == crt_pkg::CU_QUOTE)
        begin
            quote_next = crt_pkg::QM_LITERAL;
        end
        else if (open_reg == crt_pkg::STR_UNSET || crt_pkg::is_special(cu))
        begin
            own_v    = 1'b1;
            own.kind = crt_pkg::KIND_ERROR;
            fail     = 1'b1;
        end
        else
        begin
            own_v        = 1'b1;
            own.char_out = cu;
            if (in_chars_reg)
            begin
                seen_next = 1'b1;
                own.kind  = crt_pkg::KIND_CHARS;
            end
            else
            begin
                own.kind  = crt_pkg::KIND_EXT;
            end
        end

        if (fail && !last)
        begin
            err_next = 1'b1;
        end
        else if (!fail && !err_reg && last)
        begin
            // close the pattern on the updated state
            cls_v = 1'b1;
            if (open_next == crt_pkg::STR_UNSET)
            begin
                cls.kind = crt_pkg::KIND_NONE;
            end
            else if (!seen_next)
            begin
                cls.kind = crt_pkg::KIND_ERROR;
            end
            else
            begin
                cls.kind     = crt_pkg::KIND_ENTRY;
                cls.strength = open_next;
            end
        end

        if (last)
        begin
            open_next     = crt_pkg::STR_UNSET;
            in_chars_next = 1'b1;
            quote_next    = crt_pkg::QM_OFF;
            seen_next     = 1'b0;
            err_next      = 1'b0;
        end

        own.run_last = 1'b1;
        cls.run_last = 1'b1;
        if (own_v && cls_v)
        begin
            own.run_last = 1'b0;
            res0   = own;
            res1   = cls;
            push_n = 2'd2;
        end
        else if (own_v)
        begin
            res0   = own;
            res1   = cls;
            push_n = 2'd1;
        end
        else if (cls_v)
        begin
            res0   = cls;
            res1   = own;
            push_n = 2'd1;
        end
        else
        begin
            res0   = own;
            res1   = cls;
            push_n = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= crt_pkg::STR_UNSET;
            in_chars_reg <= 1'b1;
            quote_reg    <= crt_pkg::QM_OFF;
            seen_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end
        else if (fire)
        begin
            open_reg     <= open_next;
            in_chars_reg <= in_chars_next;
            quote_reg    <= quote_next;
            seen_reg     <= seen_next;
            err_reg      <= err_next;
        end
    end

    // Held error produces nothing
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && err_reg |-> push_n == 2'd0)
        else $error("result produced while error held");

    // A final unit always leaves the tokenizer in its reset state
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> open_reg == crt_pkg::STR_UNSET && !err_reg && !seen_reg)
        else $error("pattern end did not return to reset");

endmodule

// ----- rtl/core/crt_result_fifo.sv -----
// ----------------------------------------------------------------------------
// crt_result_fifo
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module crt_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_n,
    input  crt_pkg::result_t     wr0,
    input  crt_pkg::result_t     wr1,
    output logic                 room2,
    output logic                 out_valid,
    input  logic                 out_ready,
    output crt_pkg::result_t     head
);

    localparam int PW = $clog2(crt_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(crt_pkg::FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(crt_pkg::FIFO_DEPTH);
    localparam logic [CW-1:0] ROOM_C  = CW'(crt_pkg::FIFO_DEPTH - 2);

    crt_pkg::result_t mem_reg [crt_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [PW-1:0] wr_plus1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign room2     = (count_reg <= ROOM_C);
    assign head      = mem_reg[rd_reg];
    assign wr_plus1  = wr_reg + PW'(1);
    assign count_next = count_reg + CW'(push_n) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_reg] <= wr0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_plus1] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + PW'(push_n);
            rd_reg    <= rd_reg + PW'(pop);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 |-> room2)
        else $error("push without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push_n == 2'd0 |=> count_reg == $past(count_reg) - CW'(1))
        else $error("count did not drop on pop");

endmodule

// ----- rtl/core/collation_rule_tokenizer.sv -----
// ----------------------------------------------------------------------------
// collation_rule_tokenizer
// Tokenizes a collation rule pattern, one UTF-16 code unit per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one code unit and a pattern_end flag. The unit
// is captured in an input register and decoded from there, once the result
// queue has room, against the tokenizer state (open strength, chars/extension
// part, quote mode, error hold); that decode writes zero, one or two results
// into a four-entry result queue whose head drives the output ports. Results
// are registered in the queue before they reach the output ports.
// The decode stage fires whenever the queue has room for two results, so with
// the output side ready a new unit is taken every cycle, and the sustained
// rate is one unit per cycle as long as units yield at most one result each;
// a unit that yields two (content plus the pattern close) needs an extra
// output transfer. run_last marks the last result caused by a unit. After a
// format error, units are dropped without results until pattern_end.
// ----------------------------------------------------------------------------
module collation_rule_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        pattern_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] char_out,
    output logic [2:0]  entry_strength,
    output logic        run_last
);

    // input register
    logic        in_v_reg;
    logic [15:0] cu_reg;
    logic        last_reg;

    logic             room2;
    logic             fire;      // decode stage consumes the held unit
    logic [1:0]       push_n;
    logic [1:0]       push_q;
    crt_pkg::result_t res0, res1, head;

    assign fire     = in_v_reg && room2;
    assign in_ready = !in_v_reg || fire;
    assign push_q   = fire ? push_n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cu_reg   <= code_unit;
            last_reg <= pattern_end;
        end
    end

    crt_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cu     (cu_reg),
        .last   (last_reg),
        .push_n (push_n),
        .res0   (res0),
        .res1   (res1)
    );

    crt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_q),
        .wr0       (res0),
        .wr1       (res1),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind           = head.kind;
    assign char_out       = head.char_out;
    assign entry_strength = head.strength;
    assign run_last       = head.run_last;

endmodule

// ----- tb/sv/tb_collation_rule_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tb_collation_rule_tokenizer
// Self-checking bench for the collation rule tokenizer.
// ----------------------------------------------------------------------------
// Rule patterns are fed one code unit per transfer. A behavioral tokenizer in
// the bench follows every accepted unit and queues the results it should
// cause. Each result transfer from the block is checked field by field
// against the oldest queued one. A short directed set covers the relation
// symbols, quoting, extension text, errors and pattern close. Random patterns
// follow, mostly well formed with some broken ones and plain noise. These run
// under four handshake phases: no idling, a slow sender, a stalling receiver,
// and both.
// ----------------------------------------------------------------------------
module tb_collation_rule_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    // One queued input transfer
    typedef struct packed {
        logic [15:0] cu;
        logic        last;
    } rule_unit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] code_unit = '0;
    logic        pattern_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [15:0] char_out;
    logic [2:0]  entry_strength;
    logic        run_last;

    collation_rule_tokenizer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .code_unit      (code_unit),
        .pattern_end    (pattern_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .char_out       (char_out),
        .entry_strength (entry_strength),
        .run_last       (run_last)
    );

    always #5 clk = ~clk;

    // Stimulus and scoreboard storage
    rule_unit_t       unit_queue[$];     // units waiting for the driver
    crt_pkg::result_t awaited_tokens[$]; // results the block still owes
    logic [15:0]      draft[$];          // pattern under construction
    crt_pkg::result_t head_token;
    int               units_queued = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    bit               mismatch_seen = 1'b0;

    // Tokenizer state as the bench sees it
    logic [2:0]  tok_open_strength;
    logic        tok_in_chars;
    logic [1:0]  tok_quote;
    logic        tok_chars_seen;
    logic        tok_error_hold;

    // ------------------------------------------------------------------
    // Behavioral tokenizer
    // ------------------------------------------------------------------
    function automatic crt_pkg::result_t make_token(logic [2:0] k, logic [15:0] ch,
                                                    logic [2:0] st);
        crt_pkg::result_t t;
        t.kind     = k;
        t.char_out = ch;
        t.strength = st;
        t.run_last = 1'b0;
        return t;
    endfunction

    task automatic clear_tokenizer();
        tok_open_strength = crt_pkg::STR_UNSET;
        tok_in_chars      = 1'b1;
        tok_quote         = crt_pkg::QM_OFF;
        tok_chars_seen    = 1'b0;
        tok_error_hold    = 1'b0;
    endtask

    // Quoted text lands in chars while chars is empty or still active.
    function automatic crt_pkg::result_t quoted_token(logic [15:0] cu);
        if (!tok_chars_seen || tok_in_chars)
        begin
            tok_chars_seen = 1'b1;
            return make_token(crt_pkg::KIND_CHARS, cu, 3'd0);
        end
        return make_token(crt_pkg::KIND_EXT, cu, 3'd0);
    endfunction

    task automatic tokenize_unit(logic [15:0] cu, logic last);
        crt_pkg::result_t tok[$];
        logic [2:0]       rel;
        bit               failed;
        bit               syntax_char;
        bit               blank;
        failed = 1'b0;
        rel = (cu == crt_pkg::CU_LESS)  ? crt_pkg::STR_PRIMARY   :
              (cu == crt_pkg::CU_SEMI)  ? crt_pkg::STR_SECONDARY :
              (cu == crt_pkg::CU_COMMA) ? crt_pkg::STR_TERTIARY  :
              (cu == crt_pkg::CU_EQUAL) ? crt_pkg::STR_IDENTICAL :
              (cu == crt_pkg::CU_AMP)   ? crt_pkg::STR_RESET     : crt_pkg::STR_UNSET;
        syntax_char = (cu >= 16'h0020 && cu <= 16'h002F) ||
                      (cu >= 16'h003A && cu <= 16'h003F) ||
                      (cu >= 16'h005B && cu <= 16'h0060) ||
                      (cu >= 16'h007B && cu <= 16'h007E);
        blank = (cu == crt_pkg::CU_TAB) || (cu == crt_pkg::CU_LF) ||
                (cu == crt_pkg::CU_FF) || (cu == crt_pkg::CU_CR) ||
                (cu == crt_pkg::CU_SPACE);

        // After an error everything is swallowed until the pattern ends
        if (tok_error_hold)
        begin
            if (last)
                clear_tokenizer();
            return;
        end

        if (tok_quote == crt_pkg::QM_LITERAL)
        begin
            tok.push_back(quoted_token(cu));
            tok_quote = crt_pkg::QM_INSIDE;
        end
        else if (tok_quote == crt_pkg::QM_INSIDE)
        begin
            if (cu == crt_pkg::CU_QUOTE)
                tok_quote = crt_pkg::QM_OFF;
            else
                tok.push_back(quoted_token(cu));
        end
        else if (rel != crt_pkg::STR_UNSET)
        begin
            if (tok_open_strength == crt_pkg::STR_UNSET)
            begin
                tok_open_strength = rel;
            end
            else if (!tok_chars_seen)
            begin
                tok.push_back(make_token(crt_pkg::KIND_ERROR, 16'h0000, 3'd0));
                failed = 1'b1;
            end
            else
            begin
                // second symbol: close the open entry, open the next
                tok.push_back(make_token(crt_pkg::KIND_ENTRY, 16'h0000,
                                         tok_open_strength));
                tok_open_strength = rel;
                tok_in_chars      = 1'b1;
                tok_quote         = crt_pkg::QM_OFF;
                tok_chars_seen    = 1'b0;
            end
        end
        else if (blank)
        begin
            // skipped
        end
        else if (cu == crt_pkg::CU_SLASH)
        begin
            tok_in_chars = 1'b0;
        end
        else if (cu == crt_pkg::CU_QUOTE)
        begin
            tok_quote = crt_pkg::QM_LITERAL;
        end
        else if (tok_open_strength == crt_pkg::STR_UNSET || syntax_char)
        begin
            tok.push_back(make_token(crt_pkg::KIND_ERROR, 16'h0000, 3'd0));
            failed = 1'b1;
        end
        else if (tok_in_chars)
        begin
            tok_chars_seen = 1'b1;
            tok.push_back(make_token(crt_pkg::KIND_CHARS, cu, 3'd0));
        end
        else
        begin
            tok.push_back(make_token(crt_pkg::KIND_EXT, cu, 3'd0));
        end

        if (failed)
        begin
            if (last)
                clear_tokenizer();
            else
                tok_error_hold = 1'b1;
        end
        else if (last)
        begin
            // pattern close
            if (tok_open_strength == crt_pkg::STR_UNSET)
                tok.push_back(make_token(crt_pkg::KIND_NONE, 16'h0000, 3'd0));
            else if (!tok_chars_seen)
                tok.push_back(make_token(crt_pkg::KIND_ERROR, 16'h0000, 3'd0));
            else
                tok.push_back(make_token(crt_pkg::KIND_ENTRY, 16'h0000,
                                         tok_open_strength));
            clear_tokenizer();
        end

        if (tok.size() > 0)
            tok[tok.size() - 1].run_last = 1'b1;
        foreach (tok[i])
            awaited_tokens.push_back(tok[i]);
    endtask

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: input channel from unit_queue, random stalls on the output
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            code_unit   <= '0;
            pattern_end <= 1'b0;
            out_ready   <= 1'b0;
        end
        else
        begin
            // only move on once the current unit has been taken
            if (!in_valid || in_ready)
            begin
                if (unit_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    code_unit   <= unit_queue[0].cu;
                    pattern_end <= unit_queue[0].last;
                    void'(unit_queue.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input transfers, check on output transfers
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tokenizer();
        end
        else
        begin
            if (in_valid && in_ready)
                tokenize_unit(code_unit, pattern_end);
            if (out_valid && out_ready)
            begin
                if (awaited_tokens.size() == 0)
                begin
                    $display({"%0t: unexpected result, expected none, ",
                              "actual kind %0d char %h strength %0d last %0b"},
                             $time, kind, char_out, entry_strength, run_last);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    head_token = awaited_tokens.pop_front();
                    check_field("kind", 16'(head_token.kind), 16'(kind));
                    check_field("char_out", head_token.char_out, char_out);
                    check_field("entry_strength", 16'(head_token.strength),
                                16'(entry_strength));
                    check_field("run_last", 16'(head_token.run_last), 16'(run_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_unit(logic [15:0] cu, logic last);
        rule_unit_t u;
        u.cu   = cu;
        u.last = last;
        unit_queue.push_back(u);
        units_queued++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_unit({8'h00, s[i]}, i == s.len() - 1);
    endtask

    // Ordinary text: never a symbol, blank, quote or special
    function automatic logic [15:0] plain_unit();
        case ($urandom_range(0, 4))
            0:       return 16'(16'h0041 + $urandom_range(0, 25));
            1:       return 16'(16'h0061 + $urandom_range(0, 25));
            2:       return 16'(16'h0030 + $urandom_range(0, 9));
            3:       return 16'($urandom_range(16'h0080, 16'hFFFF));
            default: return 16'($urandom_range(0, 8));
        endcase
    endfunction

    function automatic logic [15:0] relation_unit();
        case ($urandom_range(0, 4))
            0:       return crt_pkg::CU_LESS;
            1:       return crt_pkg::CU_SEMI;
            2:       return crt_pkg::CU_COMMA;
            3:       return crt_pkg::CU_EQUAL;
            default: return crt_pkg::CU_AMP;
        endcase
    endfunction

    function automatic logic [15:0] space_unit();
        case ($urandom_range(0, 4))
            0:       return crt_pkg::CU_TAB;
            1:       return crt_pkg::CU_LF;
            2:       return crt_pkg::CU_FF;
            3:       return crt_pkg::CU_CR;
            default: return crt_pkg::CU_SPACE;
        endcase
    endfunction

    function automatic logic [15:0] noise_unit();
        case ($urandom_range(0, 7))
            0:       return relation_unit();
            1:       return space_unit();
            2:       return crt_pkg::CU_QUOTE;
            3:       return crt_pkg::CU_SLASH;
            4:       return 16'($urandom_range(16'h0020, 16'h007E));
            5:       return plain_unit();
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // A run of text; some pieces quoted, the first quoted unit may be anything
    task automatic draft_segment();
        int pieces;
        pieces = $urandom_range(1, 3);
        repeat (pieces)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                draft.push_back(crt_pkg::CU_QUOTE);
                draft.push_back(noise_unit());
                if ($urandom_range(0, 1) == 1)
                    draft.push_back(plain_unit());
                draft.push_back(crt_pkg::CU_QUOTE);
            end
            else
            begin
                draft.push_back(plain_unit());
            end
            if ($urandom_range(0, 7) == 0)
                draft.push_back(space_unit());
        end
    endtask

    // Mostly well-formed patterns with random content, some with one unit
    // broken, the rest pure noise.
    task automatic queue_random_pattern();
        int style;
        int entries;
        int len;
        style = $urandom_range(0, 99);
        draft.delete();
        if (style >= 85)
        begin
            len = $urandom_range(1, 8);
            repeat (len) draft.push_back(noise_unit());
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                draft.push_back(space_unit());
            if ($urandom_range(0, 19) != 0)
                draft.push_back(relation_unit());
            entries = $urandom_range(1, 4);
            for (int e = 0; e < entries; e++)
            begin
                if (e > 0)
                    draft.push_back(relation_unit());
                if ($urandom_range(0, 19) != 0)
                    draft_segment();
                if ($urandom_range(0, 2) == 0)
                begin
                    draft.push_back(crt_pkg::CU_SLASH);
                    if ($urandom_range(0, 3) != 0)
                        draft_segment();
                end
            end
            if ($urandom_range(0, 9) == 0)
                draft.push_back(crt_pkg::CU_QUOTE);   // quote as the final unit
            if (style >= 70 && draft.size() > 0)
                draft[$urandom_range(0, draft.size() - 1)] = noise_unit();
        end
        foreach (draft[i])
            push_unit(draft[i], i == draft.size() - 1);
    endtask

    task automatic wait_drained();
        while (unit_queue.size() > 0 || in_valid || awaited_tokens.size() > 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int send_idle[4];
        int recv_stall[4];
        int phase_start;
        send_idle  = '{0, 71, 0, 24};
        recv_stall = '{0, 0, 71, 24};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: each strength, blanks, extension, quoting rules,
        // errors with and without hold, pattern close variants, extremes.
        queue_text("& a/b ,c");
        queue_text("<a;b");
        queue_text("x");          // text before any symbol
        queue_text("'");          // lone quote closes an empty pattern
        queue_text(";'");         // quote last, chars still empty
        queue_text("=''a'");      // quote right after a quote is literal
        queue_text("<;,");        // empty chars at second symbol, then hold
        push_unit(crt_pkg::CU_EQUAL, 1'b0);
        push_unit(16'hFFFF, 1'b0);
        push_unit(crt_pkg::CU_SLASH, 1'b0);
        push_unit(16'h0000, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_idle[p];
            recv_stall_pct = recv_stall[p];
            phase_start    = units_queued;
            while (units_queued - phase_start < 238)
                queue_random_pattern();
            wait_drained();
        end

        // let any stray result show up
        repeat (20) @(posedge clk);
        if (!mismatch_seen && awaited_tokens.size() == 0)
            $display("tb_collation_rule_tokenizer OK");
        else
            $display("tb_collation_rule_tokenizer NOT OK");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("tb_collation_rule_tokenizer NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/crt_pkg.sv
rtl/core/crt_parse.sv
rtl/core/crt_result_fifo.sv
rtl/core/collation_rule_tokenizer.sv
tb/sv/tb_collation_rule_tokenizer.sv
